@@ rtl/coal_pkg.sv @@
package coal_pkg;

  localparam int FILL_W    = 7;
  localparam int IDLE_W    = 16;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [FILL_W-1:0] DEFAULT_MTU    = 7'd23;
  localparam logic [FILL_W-1:0] HEADER_BYTES   = 7'd3;
  localparam logic [FILL_W-1:0] CHUNK_SIZE_RST = DEFAULT_MTU - HEADER_BYTES;
  localparam logic [IDLE_W-1:0] TIMEOUT_RST    = 16'd10;
  localparam logic [IDLE_W-1:0] IDLE_MAX       = 16'hffff;

  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 2'd1;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

  // chunk descriptor handed from front to drain
  typedef struct packed {
    logic              bank;
    logic [FILL_W-1:0] len;
  } chunk_t;

  // bank handed back once its last byte has been read
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

@@ rtl/coal_front.sv @@
module coal_front #(
  parameter int BUF_BYTES = 64,
  parameter int IDX_W     = 6
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [coal_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [coal_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  coal_pkg::action_t               in_action,
  input  logic [coal_pkg::BYTE_W-1:0]     in_byte,
  input  logic                            in_link_up,
  output logic                            wr_en,
  output logic [IDX_W:0]                  wr_addr,
  output logic [coal_pkg::BYTE_W-1:0]     wr_data,
  output logic                            chunk_valid,
  input  logic                            chunk_ready,
  output coal_pkg::chunk_t                chunk,
  input  coal_pkg::rel_t                  rel
);

  localparam logic [coal_pkg::FILL_W-1:0] BUF_LIMIT = coal_pkg::FILL_W'(BUF_BYTES);

  logic [coal_pkg::FILL_W-1:0] chunk_size_r, chunk_size_nxt;
  logic [coal_pkg::IDLE_W-1:0] timeout_r, timeout_nxt;
  logic [coal_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic [coal_pkg::IDLE_W-1:0] idle_r, idle_nxt;
  logic                        wbank_r, wbank_nxt;
  logic [1:0]                  busy_r, busy_nxt;

  logic [coal_pkg::FILL_W-1:0] eff_max;
  logic [coal_pkg::IDLE_W-1:0] limit;
  logic [coal_pkg::FILL_W-1:0] fill_add;
  logic [coal_pkg::IDLE_W-1:0] idle_inc;
  logic                        accept;
  logic                        has_room;
  logic                        emit;
  logic [coal_pkg::FILL_W-1:0] emit_len;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy_r[wbank_r] && chunk_ready;
  assign accept    = in_valid && in_ready;
  assign has_room  = fill_r < BUF_LIMIT;

  always_comb begin
    if (chunk_size_r == '0) begin
      eff_max = coal_pkg::FILL_W'(1);
    end else if (chunk_size_r > BUF_LIMIT) begin
      eff_max = BUF_LIMIT;
    end else begin
      eff_max = chunk_size_r;
    end
    limit = (timeout_r == '0) ? coal_pkg::IDLE_W'(1) : timeout_r;
  end

  always_comb begin
    fill_add = has_room ? fill_r + coal_pkg::FILL_W'(1) : fill_r;
    idle_inc = (idle_r != coal_pkg::IDLE_MAX) ? idle_r + coal_pkg::IDLE_W'(1) : idle_r;
    fill_nxt = fill_r;
    idle_nxt = idle_r;
    emit     = 1'b0;
    emit_len = fill_r;
    if (accept) begin
      if (!in_link_up) begin
        fill_nxt = '0;
        idle_nxt = '0;
      end else if (in_action == coal_pkg::ACT_BYTE) begin
        fill_nxt = fill_add;
        idle_nxt = '0;
        emit_len = fill_add;
        emit     = fill_add >= eff_max;
      end else if (fill_r == '0) begin
        idle_nxt = '0;
      end else begin
        idle_nxt = idle_inc;
        emit     = idle_inc >= limit;
      end
      if (emit) begin
        fill_nxt = '0;
        idle_nxt = '0;
      end
    end
  end

  always_comb begin
    busy_nxt  = busy_r;
    wbank_nxt = wbank_r;
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (emit) begin
      busy_nxt[wbank_r] = 1'b1;
      wbank_nxt         = !wbank_r;
    end
  end

  always_comb begin
    chunk_size_nxt = chunk_size_r;
    timeout_nxt    = timeout_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        coal_pkg::REG_CHUNK_SIZE:   chunk_size_nxt = cfg_data[coal_pkg::FILL_W-1:0];
        coal_pkg::REG_IDLE_TIMEOUT: timeout_nxt    = cfg_data;
        default: ;
      endcase
    end
  end

  assign wr_en       = accept && in_link_up && (in_action == coal_pkg::ACT_BYTE) && has_room;
  assign wr_addr     = {wbank_r, fill_r[IDX_W-1:0]};
  assign wr_data     = in_byte;
  assign chunk_valid = emit;
  assign chunk.bank  = wbank_r;
  assign chunk.len   = emit_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_size_r <= coal_pkg::CHUNK_SIZE_RST;
      timeout_r    <= coal_pkg::TIMEOUT_RST;
      fill_r       <= '0;
      idle_r       <= '0;
      wbank_r      <= 1'b0;
      busy_r       <= '0;
    end else begin
      chunk_size_r <= chunk_size_nxt;
      timeout_r    <= timeout_nxt;
      fill_r       <= fill_nxt;
      idle_r       <= idle_nxt;
      wbank_r      <= wbank_nxt;
      busy_r       <= busy_nxt;
    end
  end

endmodule

@@ rtl/coal_queue.sv @@
module coal_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  coal_pkg::chunk_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output coal_pkg::chunk_t pop_data
);

  coal_pkg::chunk_t entry_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             push, pop;

  assign push_ready = count_r != 2'd2;
  assign pop_valid  = count_r != 2'd0;
  assign pop_data   = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/coal_drain.sv @@
module coal_drain #(
  parameter int IDX_W = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [IDX_W:0]              wr_addr,
  input  logic [coal_pkg::BYTE_W-1:0] wr_data,
  input  logic                        chunk_valid,
  output logic                        chunk_ready,
  input  coal_pkg::chunk_t            chunk,
  output coal_pkg::rel_t              rel,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [coal_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_last
);

  localparam int MEM_DEPTH = 2 * (2 ** IDX_W);

  // two banks: front fills one while the other drains
  logic [coal_pkg::BYTE_W-1:0] mem [MEM_DEPTH];

  logic                        active_r, active_nxt;
  logic                        bank_r, bank_nxt;
  logic [coal_pkg::FILL_W-1:0] len_r, len_nxt;
  logic [coal_pkg::FILL_W-1:0] idx_r, idx_nxt;
  logic                        valid_r, valid_nxt;
  logic                        last_r, last_nxt;
  logic [coal_pkg::BYTE_W-1:0] byte_r;
  logic                        load;
  logic                        is_last;
  logic [IDX_W:0]              rd_addr;

  assign load        = active_r && (!valid_r || out_ready);
  assign is_last     = (idx_r + coal_pkg::FILL_W'(1)) == len_r;
  assign rd_addr     = {bank_r, idx_r[IDX_W-1:0]};
  assign chunk_ready = !active_r;
  assign rel.valid   = load && is_last;
  assign rel.bank    = bank_r;
  assign out_valid   = valid_r;
  assign out_byte    = byte_r;
  assign out_last    = last_r;

  always_comb begin
    active_nxt = active_r;
    bank_nxt   = bank_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    valid_nxt  = valid_r;
    last_nxt   = last_r;
    if (out_ready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
      last_nxt  = is_last;
      idx_nxt   = idx_r + coal_pkg::FILL_W'(1);
      if (is_last) begin
        active_nxt = 1'b0;
      end
    end else if (!active_r && chunk_valid) begin
      active_nxt = 1'b1;
      bank_nxt   = chunk.bank;
      len_nxt    = chunk.len;
      idx_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read straight into the output stage
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    bank_r <= bank_nxt;
    len_r  <= len_nxt;
    idx_r  <= idx_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      valid_r  <= valid_nxt;
    end
  end

endmodule

@@ rtl/payload_coalescer_with_idle_flush.sv @@
// one input transaction per cycle while the bank being filled is free; both
// banks holding unsent chunks stall the input until the drain frees one.
// a completed chunk's descriptor goes through the queue to the drain, which reads
// one byte per cycle while the output is not stalled from the single read port of
// the chunk memory, and takes the next chunk only after the last byte is read.
// rst_n (synchronous, active low) empties both banks and the queue and restores
// the chunk size to 20 and idle_timeout_ticks to 10; chunk memory is not cleared.
module payload_coalescer_with_idle_flush #(
  parameter int BUF_BYTES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [coal_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [coal_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // byte_value[7:0], link_up[8], zeros
  input  logic                            in_tuser,   // action
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // out_byte[7:0]
  output logic                            out_tlast   // last_of_chunk
);

  localparam int IDX_W = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;

  logic                        wr_en;
  logic [IDX_W:0]              wr_addr;
  logic [coal_pkg::BYTE_W-1:0] wr_data;
  logic                        push_valid, push_ready;
  coal_pkg::chunk_t            push_data;
  logic                        pop_valid, pop_ready;
  coal_pkg::chunk_t            pop_data;
  coal_pkg::rel_t              rel;
  coal_pkg::action_t           action;

  assign action = coal_pkg::action_t'(in_tuser);

  coal_front #(
    .BUF_BYTES (BUF_BYTES),
    .IDX_W     (IDX_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_action   (action),
    .in_byte     (in_tdata[7:0]),
    .in_link_up  (in_tdata[8]),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .chunk_valid (push_valid),
    .chunk_ready (push_ready),
    .chunk       (push_data),
    .rel         (rel)
  );

  coal_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  coal_drain #(
    .IDX_W (IDX_W)
  ) u_drain (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .chunk_valid (pop_valid),
    .chunk_ready (pop_ready),
    .chunk       (pop_data),
    .rel         (rel),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_byte    (out_tdata),
    .out_last    (out_tlast)
  );

endmodule

@@ tb/tb_payload_coalescer_with_idle_flush.sv @@
`timescale 1ns / 1ps

module tb_payload_coalescer_with_idle_flush;
  import coal_pkg::*;

  localparam int BUF = 64;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 10;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum logic {
    ROW_CFG  = 1'b0,
    ROW_ITEM = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    action_t              act;
    logic [7:0]           value;
    logic                 link;
    logic                 typed;
    logic [7:0]           exp_value;
    logic                 exp_last;
  } plan_row_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } chunk_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic out_tlast;

  // shadow of the block's registers and chunk state
  logic [FILL_W-1:0] max_pl;
  logic [IDLE_W-1:0] idle_lim;
  logic [7:0]        shadow_store [BUF];
  int unsigned       fill;
  logic [IDLE_W-1:0] idle_ticks;

  chunk_byte_t awaited_bytes[$];
  plan_row_t   plan[$];

  bit steady = 1'b0;
  int mismatches = 0;
  int items_sent = 0;
  int bytes_seen = 0;
  int chunks_seen = 0;
  int settings_used = 0;
  int cycles = 0;

  payload_coalescer_with_idle_flush #(.BUF_BYTES(BUF)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still awaited", cycles,
               awaited_bytes.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (steady) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= 37);
    end
  end

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at cycle %0d: %s", cycles, what);
    end
  endtask

  always @(posedge clk) begin : watch_out
    chunk_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      bytes_seen++;
      if (out_tlast) begin
        chunks_seen++;
      end
      if (awaited_bytes.size() == 0) begin
        note_mismatch($sformatf("unexpected byte %02h last %0b", out_tdata, out_tlast));
      end else begin
        want = awaited_bytes.pop_front();
        if (out_tdata !== want.value || out_tlast !== want.last) begin
          note_mismatch($sformatf("byte exp %02h got %02h, last exp %0b got %0b",
                                  want.value, out_tdata, want.last, out_tlast));
        end
      end
    end
  end

  // hand the pending chunk to the expectation queue if keep is set, then clear it
  task automatic flush_chunk(input bit keep);
    chunk_byte_t e;
    for (int i = 0; i < fill; i++) begin
      e.value = shadow_store[i];
      e.last  = (i + 1 == fill);
      if (keep) begin
        awaited_bytes.push_back(e);
      end
    end
    fill = 0;
    idle_ticks = '0;
  endtask

  task automatic coalesce_step(input action_t act, input logic [7:0] b, input logic lk,
                               input bit keep);
    int unsigned cap;
    int unsigned lim;
    if (!lk) begin
      fill = 0;
      idle_ticks = '0;
    end else if (act == ACT_BYTE) begin
      if (fill < BUF) begin
        shadow_store[fill] = b;
        fill++;
      end
      idle_ticks = '0;
      cap = (max_pl == 0) ? 1 : ((max_pl > BUF) ? BUF : max_pl);
      if (fill >= cap) begin
        flush_chunk(keep);
      end
    end else if (fill == 0) begin
      idle_ticks = '0;
    end else begin
      if (idle_ticks != IDLE_MAX) begin
        idle_ticks++;
      end
      lim = (idle_lim == 0) ? 1 : idle_lim;
      if (idle_ticks >= lim) begin
        flush_chunk(keep);
      end
    end
  endtask

  // registers change only once the output side has drained and settled
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    in_tvalid <= 1'b0;
    while (awaited_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_CHUNK_SIZE) begin
      max_pl = d[FILL_W-1:0];
    end else if (idx == REG_IDLE_TIMEOUT) begin
      idle_lim = d;
    end
  endtask

  task automatic send_item(input action_t act, input logic [7:0] b, input logic lk,
                           input bit keep);
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, lk, b};
    in_tuser  <= act;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    coalesce_step(act, b, lk, keep);
    if (!steady && $urandom_range(0, 99) < 37) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] d);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = d;
    return r;
  endfunction

  function automatic plan_row_t item_row(input action_t act, input logic [7:0] v,
                                         input logic lk, input logic typed,
                                         input logic [7:0] ev, input logic el);
    plan_row_t r;
    r = '0;
    r.kind      = ROW_ITEM;
    r.act       = act;
    r.value     = v;
    r.link      = lk;
    r.typed     = typed;
    r.exp_value = ev;
    r.exp_last  = el;
    return r;
  endfunction

  initial begin
    int unsigned n_items;
    int unsigned tick_pct;
    logic [FILL_W-1:0] mp;
    logic [IDLE_W-1:0] to;
    logic [8:0] upper;
    action_t act;
    logic [7:0] b;
    logic lk;

    max_pl     = CHUNK_SIZE_RST;
    idle_lim   = TIMEOUT_RST;
    fill       = 0;
    idle_ticks = '0;

    // tick with nothing pending, then a byte while the link is down
    plan.push_back(item_row(ACT_TICK, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0));
    plan.push_back(item_row(ACT_BYTE, 8'hff, 1'b0, 1'b0, 8'h00, 1'b0));
    // payload zero behaves as one byte per chunk; upper data bits are masked
    plan.push_back(cfg_row(REG_CHUNK_SIZE, 16'hff80));
    plan.push_back(item_row(ACT_BYTE, 8'h00, 1'b1, 1'b1, 8'h00, 1'b1));
    plan.push_back(item_row(ACT_BYTE, 8'hff, 1'b1, 1'b1, 8'hff, 1'b1));
    // oversized payload saturates, spare indexes are ignored, timeout zero acts as one
    plan.push_back(cfg_row(REG_CHUNK_SIZE, 16'd127));
    plan.push_back(cfg_row(REG_SPARE_A, 16'd5));
    plan.push_back(cfg_row(REG_SPARE_B, 16'hffff));
    plan.push_back(cfg_row(REG_IDLE_TIMEOUT, 16'd0));
    plan.push_back(item_row(ACT_BYTE, 8'h5a, 1'b1, 1'b0, 8'h00, 1'b0));
    plan.push_back(item_row(ACT_TICK, 8'h00, 1'b1, 1'b1, 8'h5a, 1'b1));
    // link drop discards the pending byte before the timeout fires
    plan.push_back(cfg_row(REG_IDLE_TIMEOUT, 16'd2));
    plan.push_back(cfg_row(REG_CHUNK_SIZE, 16'd3));
    plan.push_back(item_row(ACT_BYTE, 8'h11, 1'b1, 1'b0, 8'h00, 1'b0));
    plan.push_back(item_row(ACT_BYTE, 8'h22, 1'b0, 1'b0, 8'h00, 1'b0));
    plan.push_back(item_row(ACT_BYTE, 8'h33, 1'b1, 1'b0, 8'h00, 1'b0));
    plan.push_back(item_row(ACT_TICK, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0));
    plan.push_back(item_row(ACT_TICK, 8'h00, 1'b1, 1'b1, 8'h33, 1'b1));
    // payload lowered under pending bytes: the whole backlog leaves as one chunk
    plan.push_back(cfg_row(REG_CHUNK_SIZE, 16'd20));
    plan.push_back(item_row(ACT_BYTE, 8'h01, 1'b1, 1'b0, 8'h00, 1'b0));
    plan.push_back(item_row(ACT_BYTE, 8'h02, 1'b1, 1'b0, 8'h00, 1'b0));
    plan.push_back(item_row(ACT_BYTE, 8'h03, 1'b1, 1'b0, 8'h00, 1'b0));
    plan.push_back(cfg_row(REG_CHUNK_SIZE, 16'd2));
    plan.push_back(item_row(ACT_BYTE, 8'h04, 1'b1, 1'b0, 8'h00, 1'b0));
    // longest timeout never fires here
    plan.push_back(cfg_row(REG_IDLE_TIMEOUT, 16'hffff));
    plan.push_back(item_row(ACT_BYTE, 8'h80, 1'b1, 1'b0, 8'h00, 1'b0));
    plan.push_back(item_row(ACT_TICK, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0));
    plan.push_back(item_row(ACT_TICK, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        if (plan[i].typed) begin
          awaited_bytes.push_back('{plan[i].exp_value, plan[i].exp_last});
        end
        send_item(plan[i].act, plan[i].value, plan[i].link, !plan[i].typed);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      n_items  = 32;
      tick_pct = 30;
      upper    = '0;
      case (ph)
        0: begin
          mp = CHUNK_SIZE_RST;
          to = TIMEOUT_RST;
        end
        1: begin
          mp = 7'd1;
          to = 16'd1;
        end
        2: begin
          // full-size chunks only, so mostly bytes
          mp = 7'd64;
          to = 16'hffff;
          n_items  = 80;
          tick_pct = 5;
        end
        3: begin
          mp = 7'd0;
          to = 16'd0;
          upper = 9'($urandom_range(0, 511));
        end
        4: begin
          mp = 7'd127;
          to = 16'd5;
        end
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            mp = FILL_W'($urandom_range(1, 64));
          end else begin
            mp = FILL_W'($urandom_range(1, 8));
          end
          to = IDLE_W'($urandom_range(1, 6));
          upper = 9'($urandom_range(0, 511));
        end
      endcase
      write_reg(REG_CHUNK_SIZE, {upper, mp});
      write_reg(REG_IDLE_TIMEOUT, to);
      if (ph == 7) begin
        write_reg(REG_SPARE_A, CFG_W'($urandom));
      end
      settings_used++;
      steady = (ph == 5);

      for (int k = 0; k < n_items; k++) begin
        if (ph == 6 && k == 16) begin
          // hold the sender back until the output side has caught up
          in_tvalid <= 1'b0;
          @(posedge clk);
          while (awaited_bytes.size() != 0) @(posedge clk);
        end
        act = ($urandom_range(0, 99) < tick_pct) ? ACT_TICK : ACT_BYTE;
        b   = 8'($urandom_range(0, 255));
        lk  = ($urandom_range(0, 99) >= 4);
        send_item(act, b, lk, 1'b1);
      end
    end
    steady = 1'b0;

    in_tvalid <= 1'b0;
    while (awaited_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 4) @(posedge clk);

    $display("ran %0d input transactions under %0d register settings plus directed rows",
             items_sent, settings_used);
    $display("checked %0d output bytes in %0d chunks, %0d mismatches", bytes_seen,
             chunks_seen, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
